>>> sv/b64c_pkg.sv
// b64c_pkg: types, character constants and alphabet functions of the base64 codec.
// Depends on nothing; every other file of the codec imports it.
package b64c_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECODE_MODE = 2'd0,
		REG_URL_SAFE    = 2'd1
	} reg_idx_t;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// one queued request: a whole encode group, or one decode result
	typedef struct packed {
		op_t        op;
		logic [23:0] word;
		logic [1:0] nbytes;
		logic       url;
		logic       last;
		logic [7:0] dbyte;
		logic       has;
		logic       err;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] enc_char(input logic [5:0] d, input logic url);
		logic [7:0] c;
		if (d < 6'd26)      c = 8'h41 + {2'b00, d};
		else if (d < 6'd52) c = 8'd71 + {2'b00, d};
		else if (d < 6'd62) c = {2'b00, d} - 8'd4;
		else if (d == 6'd62) c = url ? CH_MINUS : CH_PLUS;
		else                c = url ? CH_UNDER : CH_SLASH;
		return c;
	endfunction

	// bit 6 set when the character is a digit of the standard alphabet
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [7:0] t;
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			r = {1'b1, t[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'd71;
			r = {1'b1, t[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c + 8'd4;
			r = {1'b1, t[5:0]};
		end else if (c == CH_PLUS) begin
			r = {1'b1, 6'd62};
		end else if (c == CH_SLASH) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

>>> sv/b64c_if.sv
// b64c channel interfaces: input bytes, result items and configuration writes.
// Depends on b64c_pkg for the register index width.
interface b64c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface b64c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_data;
	logic       out_last;
	logic       out_error;
	modport source(output valid, out_byte, has_data, out_last, out_error, input ready);
	modport sink(input valid, out_byte, has_data, out_last, out_error, output ready);
endinterface

interface b64c_cfg_if;
	import b64c_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/b64c_front.sv
// b64c_front: accepts bytes, holds the stream state and config registers,
// and queues one request per group or decode result. Depends on b64c_pkg, b64c_if.
module b64c_front (
	input  logic                 clk,
	input  logic                 arst_n,
	b64c_in_if.sink              in_ch,
	b64c_cfg_if.sink             cfg,
	input  b64c_pkg::fifo_stat_t fstat,
	output logic                 push,
	output b64c_pkg::entry_t     entry
);
	import b64c_pkg::*;

	logic        decode_q, url_q, drop_q;
	logic [1:0]  gc_q;
	logic [15:0] held_q;
	logic [2:0]  pend_q;

	logic        accept;
	logic [1:0]  n;
	logic [23:0] v, w;
	logic [6:0]  dig;
	logic [15:0] nh, sh;
	logic [3:0]  np;
	logic [2:0]  np2;
	logic        skip_ch;

	logic        gc_clr;
	logic [1:0]  gc_d;
	logic [15:0] held_d;
	logic [2:0]  pend_d;
	logic        drop_d;

	// a config write takes the cycle; input waits for it
	assign in_ch.ready = !fstat.full && !cfg.valid;
	assign cfg.ready   = 1'b1;
	assign accept      = in_ch.valid && in_ch.ready;

	assign n  = gc_q + 2'd1;
	assign v  = {held_q, in_ch.in_byte};
	assign dig = digit_of(in_ch.in_byte);
	assign nh = {held_q[9:0], dig[5:0]};
	assign np = {1'b0, pend_q} + 4'd6;
	assign np2 = 3'(np - 4'd8);
	assign sh = nh >> np2;
	assign skip_ch = (in_ch.in_byte == CH_PAD) || (in_ch.in_byte == CH_CR) ||
			(in_ch.in_byte == CH_LF);

	always_comb begin
		unique case (n)
			2'd1:    w = v << 16;
			2'd2:    w = v << 8;
			default: w = v;
		endcase
	end

	always_comb begin
		entry        = '0;
		entry.word   = w;
		entry.nbytes = n;
		entry.url    = url_q;
		entry.last   = in_ch.in_last;
		push         = 1'b0;
		gc_d         = gc_q;
		held_d       = held_q;
		pend_d       = pend_q;
		drop_d       = drop_q;
		gc_clr       = 1'b0;
		if (!decode_q) begin
			entry.op = OP_ENC;
			if (n < 2'd3 && !in_ch.in_last) begin
				held_d = v[15:0];
				gc_d   = n;
			end else begin
				push   = 1'b1;
				gc_clr = 1'b1;
			end
		end else begin
			entry.op = OP_DEC;
			push     = 1'b1;
			priority if (drop_q || skip_ch) begin
				push   = in_ch.in_last;
				gc_clr = in_ch.in_last;
				drop_d = drop_q && !in_ch.in_last;
			end else if (!dig[6]) begin
				entry.err = 1'b1;
				gc_clr    = 1'b1;
				drop_d    = !in_ch.in_last;
			end else if (np >= 4'd8) begin
				entry.dbyte = sh[7:0];
				entry.has   = 1'b1;
				pend_d      = np2;
				held_d      = nh & ((16'd1 << np2) - 16'd1);
				gc_clr      = in_ch.in_last;
			end else begin
				push   = in_ch.in_last;
				gc_clr = in_ch.in_last;
				held_d = nh;
				pend_d = np[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_q <= 1'b0;
			url_q    <= 1'b0;
			drop_q   <= 1'b0;
			gc_q     <= '0;
			held_q   <= '0;
			pend_q   <= '0;
		end else if (cfg.valid && cfg.index == REG_DECODE_MODE) begin
			decode_q <= cfg.data;
			drop_q   <= 1'b0;
			gc_q     <= '0;
			held_q   <= '0;
			pend_q   <= '0;
		end else if (cfg.valid && cfg.index == REG_URL_SAFE) begin
			url_q <= cfg.data;
		end else if (accept) begin
			if (gc_clr) begin
				drop_q <= drop_d;
				gc_q   <= '0;
				held_q <= '0;
				pend_q <= '0;
			end else begin
				drop_q <= drop_d;
				gc_q   <= gc_d;
				held_q <= held_d;
				pend_q <= pend_d;
			end
		end
	end

endmodule

>>> sv/b64c_fifo.sv
// b64c_fifo: short request queue between front and back.
// Depends on b64c_pkg for the entry type.
module b64c_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64c_pkg::entry_t     wdata,
	input  logic                 pop,
	output b64c_pkg::entry_t     head,
	output b64c_pkg::fifo_stat_t fstat
);
	import b64c_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// storage rounded up to a power of two so the pointers wrap cleanly
	entry_t       mem [2**AW];
	logic [AW:0]  wr_q, rd_q;

	assign fstat.empty = (wr_q == rd_q);
	assign fstat.full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign head        = mem[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
		end
	end

endmodule

>>> sv/b64c_back.sv
// b64c_back: expands queued requests into result items, one per cycle
// while out_ch is ready, via a registered output stage. Depends on b64c_pkg, b64c_if.
module b64c_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64c_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	b64c_out_if.source       out_ch
);
	import b64c_pkg::*;

	logic       out_valid_q;
	logic [1:0] k_q;
	logic [7:0] byte_q;
	logic       has_q, last_q, err_q;

	logic [2:0] cnt;
	logic       last_k, load, pad;
	logic [5:0] sel;
	logic [7:0] c_byte;
	logic       c_has, c_last, c_err;

	always_comb begin
		if (head.op == OP_DEC) cnt = 3'd1;
		else if (!head.url)    cnt = 3'd4;
		else                   cnt = {1'b0, head.nbytes} + 3'd1;
	end

	assign last_k = ({1'b0, k_q} == cnt - 3'd1);
	assign load   = !empty && (!out_valid_q || out_ch.ready);
	assign pop    = load && last_k;

	always_comb begin
		unique case (k_q)
			2'd0:    sel = head.word[23:18];
			2'd1:    sel = head.word[17:12];
			2'd2:    sel = head.word[11:6];
			default: sel = head.word[5:0];
		endcase
	end

	// trailing chars beyond the bytes held become padding
	assign pad = (k_q == 2'd2 && head.nbytes < 2'd2) || (k_q == 2'd3 && head.nbytes < 2'd3);

	always_comb begin
		c_last = head.last && last_k;
		if (head.op == OP_DEC) begin
			c_byte = head.dbyte;
			c_has  = head.has;
			c_err  = head.err;
		end else begin
			c_byte = pad ? CH_PAD : enc_char(sel, head.url);
			c_has  = 1'b1;
			c_err  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			k_q         <= last_k ? 2'd0 : k_q + 2'd1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= c_byte;
			has_q  <= c_has;
			last_q <= c_last;
			err_q  <= c_err;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = byte_q;
	assign out_ch.has_data  = has_q;
	assign out_ch.out_last  = last_q;
	assign out_ch.out_error = err_q;

endmodule

>>> sv/base64_stream_codec.sv
// base64_stream_codec: streaming base64 encoder/decoder, one byte per input item.
// The first result passes through the request queue, then the output register.
// Throughput: one result per cycle out while out_ch.ready holds; encode gives 4 chars
// per 3 bytes (URL-safe: no padding) through the single output register.
// Reset (arst_n low, async): encode, standard alphabet, stream state and queue empty.
// Depends on b64c_pkg, b64c_if, b64c_front, b64c_fifo, b64c_back.
module base64_stream_codec #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input logic         clk,
	input logic         arst_n,
	b64c_in_if.sink     in_ch,
	b64c_out_if.source  out_ch,
	b64c_cfg_if.sink    cfg
);
	import b64c_pkg::*;

	fifo_stat_t fstat;
	entry_t     wr_entry, head;
	logic       push, pop;

	b64c_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.fstat  (fstat),
		.push   (push),
		.entry  (wr_entry)
	);

	b64c_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && in_ch.valid && in_ch.ready),
		.wdata  (wr_entry),
		.pop    (pop),
		.head   (head),
		.fstat  (fstat)
	);

	b64c_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (fstat.empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("pop from empty request queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && in_ch.valid && in_ch.ready) |-> !fstat.full)
		else $error("push into full request queue");

	a_pop_drives_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_ch.valid)
		else $error("request retired without a result presented");

endmodule
